// File: hdl/rism_pkg.sv
// Shared constants, codes, state encoding and key split helpers for the sparse map.
package rism_pkg;

  localparam int KEY_SPACE_DEF   = 256;
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int WORD_BITS_DEF   = 64;

  localparam int KEY_W   = 8;
  localparam int OUT_VAL_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    ACT_GET    = 2'd0,
    ACT_SET    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_GET_WAIT,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_INS_WRITE,
    ST_BASE_START,
    ST_BASE
  } state_t;

  // Word holding the key: count the word boundaries at or below it.
  // Keys are eight bits and words hold at least 32 bits, so seven compares suffice.
  function automatic int word_index(logic [KEY_W-1:0] key, int wb);
    int n;
    n = 0;
    for (int k = 1; k < 8; k++) begin
      if (int'(key) >= k * wb) n = n + 1;
    end
    return n;
  endfunction

  // Bit position of the key within its word.
  function automatic int word_pos(logic [KEY_W-1:0] key, int wb);
    int n;
    n = word_index(key, wb);
    return int'(key) - n * wb;
  endfunction

endpackage

// File: hdl/rank_indexed_sparse_map.sv
// Top level of the rank-indexed sparse map: command sequencer around two memories.
//
// A key-to-value map over an eight-bit key. A presence bitmap marks which keys
// hold a value, and the values sit densely, in key order, in a value memory of
// CAPACITY words. Each bitmap word carries a base: the number of set bits in all
// earlier words, so the slot of a key is its word's base plus the set bits below
// it in that word. Issue a command with start while busy is low; busy stays high
// until the result is out. Each command yields exactly one result word, shown for
// one cycle with out_valid; the receiver cannot stall, so capture it then.
// A miss, an overwrite, a refused set, a remove of an absent key or the unused
// action finishes from the decide state; a get that hits first waits for the
// value memory's registered read. An insert or remove moves the later entries
// one slot per cycle through the value memory's single write port, an insert
// then writes its own entry, and then the later bitmap words are walked one per
// cycle (after a start step) to adjust their bases. With the default sizes the
// worst case is an insert at slot zero, in the first bitmap word, with 63 stored
// entries. The bitmap memory comes out of reset empty through per-word valid
// bits; there is no clearing pass.
module rank_indexed_sparse_map #(
  parameter int KEY_SPACE   = rism_pkg::KEY_SPACE_DEF,
  parameter int CAPACITY    = rism_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = rism_pkg::VALUE_WIDTH_DEF,
  parameter int WORD_BITS   = rism_pkg::WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_action,
  input  logic [rism_pkg::KEY_W-1:0]       in_key,
  input  logic [rism_pkg::OUT_VAL_W-1:0]   in_value,
  output logic                             out_valid,
  output logic                             out_found,
  output logic [rism_pkg::OUT_VAL_W-1:0]   out_read_value,
  output logic                             out_full_res,
  output logic [rism_pkg::COUNT_W-1:0]     out_count
);

  localparam int NUM_WORDS = (KEY_SPACE + WORD_BITS - 1) / WORD_BITS;
  localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int POS_W     = $clog2(WORD_BITS);
  localparam int POP_W     = $clog2(CAPACITY + 1);
  localparam int AW        = $clog2(CAPACITY);
  localparam int WM_W      = WORD_BITS + POP_W;

  // Sequencer state and the latched command word.
  rism_pkg::state_t           state_r, state_nxt;
  rism_pkg::action_t          action_r;
  logic [WI_W-1:0]            wi_r;
  logic [POS_W-1:0]           pos_r;
  logic                       in_space_r;
  logic [VALUE_WIDTH-1:0]     value_r;

  // Lookup results, held for the rest of the command.
  logic                       present_r;
  logic [POP_W-1:0]           idx_r;
  logic [WORD_BITS-1:0]       bits_r;
  logic [POP_W-1:0]           base_r;

  logic [POP_W-1:0]           pop_r, pop_nxt;
  logic [AW-1:0]              sptr_r, sptr_nxt;
  logic [WI_W-1:0]            bptr_r, bptr_nxt;

  logic                       out_valid_r;
  logic                       out_found_r;
  logic [rism_pkg::OUT_VAL_W-1:0] out_value_r;
  logic                       out_full_r;
  logic [rism_pkg::COUNT_W-1:0] out_count_r;

  // Memory ports.
  logic                       vwe;
  logic [AW-1:0]              vwaddr, vraddr;
  logic [VALUE_WIDTH-1:0]     vwdata, vrdata;
  logic                       wwe;
  logic [WI_W-1:0]            wwaddr, wraddr;
  logic [WM_W-1:0]            wwdata, wrdata;

  // Rank unit outputs.
  logic                       rk_present;
  logic [POP_W-1:0]           rk_rank;

  // Result word of the finishing command.
  logic                       fin;
  logic [rism_pkg::OUT_VAL_W-1:0] fin_value;
  logic                       fin_full;

  logic [WI_W-1:0]            key_wi;
  logic [POS_W-1:0]           key_pos;
  logic                       key_in_space;
  logic [WORD_BITS-1:0]       key_bit;
  logic                       more_words;

  assign key_wi       = WI_W'(rism_pkg::word_index(in_key, WORD_BITS));
  assign key_pos      = POS_W'(rism_pkg::word_pos(in_key, WORD_BITS));
  assign key_in_space = int'(in_key) < KEY_SPACE;
  assign key_bit      = WORD_BITS'(1) << pos_r;
  assign more_words   = int'(wi_r) < NUM_WORDS - 1;

  rism_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_value_mem (
    .clk   (clk),
    .we    (vwe),
    .waddr (vwaddr),
    .wdata (vwdata),
    .raddr (vraddr),
    .rdata (vrdata)
  );

  rism_word_mem #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WM_W)
  ) u_word_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (wwe),
    .waddr (wwaddr),
    .wdata (wwdata),
    .raddr (wraddr),
    .rdata (wrdata)
  );

  rism_rank #(
    .WORD_BITS (WORD_BITS),
    .CAPACITY  (CAPACITY)
  ) u_rank (
    .word_bits (wrdata[WM_W-1:POP_W]),
    .base      (wrdata[POP_W-1:0]),
    .pos       (pos_r),
    .present   (rk_present),
    .rank      (rk_rank)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rism_pkg::ST_IDLE;
      pop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pop_r       <= pop_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    sptr_r <= sptr_nxt;
    bptr_r <= bptr_nxt;
    // Latch the command word on accept.
    if (state_r == rism_pkg::ST_IDLE && start) begin
      action_r   <= rism_pkg::action_t'(in_action);
      wi_r       <= key_wi;
      pos_r      <= key_pos;
      in_space_r <= key_in_space;
      value_r    <= VALUE_WIDTH'(in_value);
    end
    // Hold the lookup of the key's word.
    if (state_r == rism_pkg::ST_LOOKUP) begin
      present_r <= in_space_r && rk_present;
      idx_r     <= rk_rank;
      bits_r    <= wrdata[WM_W-1:POP_W];
      base_r    <= wrdata[POP_W-1:0];
    end
    if (fin) begin
      out_found_r <= present_r;
      out_value_r <= fin_value;
      out_full_r  <= fin_full;
      out_count_r <= rism_pkg::COUNT_W'(pop_nxt);
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop_nxt   = pop_r;
    sptr_nxt  = sptr_r;
    bptr_nxt  = bptr_r;
    vwe       = 1'b0;
    vwaddr    = idx_r[AW-1:0];
    vwdata    = value_r;
    vraddr    = idx_r[AW-1:0];
    wwe       = 1'b0;
    wwaddr    = wi_r;
    wwdata    = {bits_r, base_r};
    wraddr    = key_wi;
    fin       = 1'b0;
    fin_value = '0;
    fin_full  = 1'b0;

    unique case (state_r)
      rism_pkg::ST_IDLE: begin
        // Read the key's bitmap word as the command is taken.
        if (start) begin
          state_nxt = rism_pkg::ST_LOOKUP;
        end
      end

      rism_pkg::ST_LOOKUP: begin
        state_nxt = rism_pkg::ST_DECIDE;
      end

      rism_pkg::ST_DECIDE: begin
        unique case (action_r)
          rism_pkg::ACT_GET: begin
            if (present_r) begin
              state_nxt = rism_pkg::ST_GET_WAIT;
            end else begin
              fin       = 1'b1;
              state_nxt = rism_pkg::ST_IDLE;
            end
          end
          rism_pkg::ACT_SET: begin
            if (!in_space_r) begin
              fin       = 1'b1;
              state_nxt = rism_pkg::ST_IDLE;
            end else if (present_r) begin
              // Overwrite in place.
              vwe       = 1'b1;
              fin       = 1'b1;
              state_nxt = rism_pkg::ST_IDLE;
            end else if (pop_r >= POP_W'(CAPACITY)) begin
              fin_full  = 1'b1;
              fin       = 1'b1;
              state_nxt = rism_pkg::ST_IDLE;
            end else begin
              // Mark the key, then open a slot by moving later entries up.
              wwe     = 1'b1;
              wwdata  = {bits_r | key_bit, base_r};
              pop_nxt = pop_r + 1'b1;
              if (idx_r == pop_r) begin
                state_nxt = rism_pkg::ST_INS_WRITE;
              end else begin
                vraddr    = AW'(pop_r - 1'b1);
                sptr_nxt  = AW'(pop_r - 1'b1);
                state_nxt = rism_pkg::ST_SHIFT_UP;
              end
            end
          end
          rism_pkg::ACT_REMOVE: begin
            if (present_r) begin
              // Clear the key, then close its slot by moving later entries down.
              wwe     = 1'b1;
              wwdata  = {bits_r & ~key_bit, base_r};
              pop_nxt = pop_r - 1'b1;
              if ((POP_W+1)'(idx_r) + 1'b1 < (POP_W+1)'(pop_r)) begin
                vraddr    = AW'(idx_r + 1'b1);
                sptr_nxt  = AW'(idx_r + 1'b1);
                state_nxt = rism_pkg::ST_SHIFT_DN;
              end else if (more_words) begin
                state_nxt = rism_pkg::ST_BASE_START;
              end else begin
                fin       = 1'b1;
                state_nxt = rism_pkg::ST_IDLE;
              end
            end else begin
              fin       = 1'b1;
              state_nxt = rism_pkg::ST_IDLE;
            end
          end
          default: begin
            fin       = 1'b1;
            state_nxt = rism_pkg::ST_IDLE;
          end
        endcase
      end

      rism_pkg::ST_GET_WAIT: begin
        fin_value = rism_pkg::OUT_VAL_W'(vrdata);
        fin       = 1'b1;
        state_nxt = rism_pkg::ST_IDLE;
      end

      rism_pkg::ST_SHIFT_UP: begin
        // Entry at sptr is on the read port; drop it one slot higher.
        vwe    = 1'b1;
        vwaddr = sptr_r + 1'b1;
        vwdata = vrdata;
        if (POP_W'(sptr_r) == idx_r) begin
          state_nxt = rism_pkg::ST_INS_WRITE;
        end else begin
          vraddr   = sptr_r - 1'b1;
          sptr_nxt = sptr_r - 1'b1;
        end
      end

      rism_pkg::ST_SHIFT_DN: begin
        // Entry at sptr is on the read port; move it one slot lower.
        vwe    = 1'b1;
        vwaddr = sptr_r - 1'b1;
        vwdata = vrdata;
        if (POP_W'(sptr_r) < pop_r) begin
          vraddr   = sptr_r + 1'b1;
          sptr_nxt = sptr_r + 1'b1;
        end else if (more_words) begin
          state_nxt = rism_pkg::ST_BASE_START;
        end else begin
          fin       = 1'b1;
          state_nxt = rism_pkg::ST_IDLE;
        end
      end

      rism_pkg::ST_INS_WRITE: begin
        vwe = 1'b1;
        if (more_words) begin
          state_nxt = rism_pkg::ST_BASE_START;
        end else begin
          fin       = 1'b1;
          state_nxt = rism_pkg::ST_IDLE;
        end
      end

      rism_pkg::ST_BASE_START: begin
        wraddr    = wi_r + 1'b1;
        bptr_nxt  = wi_r + 1'b1;
        state_nxt = rism_pkg::ST_BASE;
      end

      rism_pkg::ST_BASE: begin
        // Adjust the base of each later word, reading the next one meanwhile.
        wwe    = 1'b1;
        wwaddr = bptr_r;
        if (action_r == rism_pkg::ACT_SET) begin
          wwdata = {wrdata[WM_W-1:POP_W], wrdata[POP_W-1:0] + 1'b1};
        end else begin
          wwdata = {wrdata[WM_W-1:POP_W], wrdata[POP_W-1:0] - 1'b1};
        end
        if (int'(bptr_r) == NUM_WORDS - 1) begin
          fin       = 1'b1;
          state_nxt = rism_pkg::ST_IDLE;
        end else begin
          wraddr   = bptr_r + 1'b1;
          bptr_nxt = bptr_r + 1'b1;
        end
      end

      default: begin
        state_nxt = rism_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = state_r != rism_pkg::ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;
  assign out_full_res   = out_full_r;
  assign out_count      = out_count_r;

endmodule

// File: hdl/rism_ram.sv
// Simple dual-port memory: one write port, one read port with registered read data.
module rism_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rism_word_mem.sv
// Bitmap word memory: presence bits and word base per entry, reads as zero until written.
module rism_word_mem #(
  parameter int DEPTH  = 4,
  parameter int WIDTH  = 71,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] raw_r;
  logic             hit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    raw_r <= mem[raddr];
  end

  // Valid bits stand in for the all-zero reset of the stored words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      hit_r <= valid_r[raddr];
    end
  end

  assign rdata = hit_r ? raw_r : '0;

endmodule

// File: hdl/rism_rank.sv
// Rank unit: presence test and slot index from one bitmap word and its base.
module rism_rank #(
  parameter int WORD_BITS = 64,
  parameter int CAPACITY  = 64,
  parameter int POS_W     = $clog2(WORD_BITS),
  parameter int POP_W     = $clog2(CAPACITY + 1)
) (
  input  logic [WORD_BITS-1:0] word_bits,
  input  logic [POP_W-1:0]     base,
  input  logic [POS_W-1:0]     pos,
  output logic                 present,
  output logic [POP_W-1:0]     rank
);

  logic [WORD_BITS-1:0] below;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      below[b] = (b < int'(pos));
    end
  end

  assign present = word_bits[pos];
  assign rank    = base + POP_W'($countones(word_bits & below));

endmodule

// File: tb/tb_rank_indexed_sparse_map.sv
// Self-checking testbench for the rank-indexed sparse map: directed, store-full and random tests.
module tb_rank_indexed_sparse_map;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_SPACE = rism_pkg::KEY_SPACE_DEF;
  localparam int CAPACITY = rism_pkg::CAPACITY_DEF;
  localparam int KEY_W = rism_pkg::KEY_W;
  localparam int OUT_VAL_W = rism_pkg::OUT_VAL_W;
  localparam int COUNT_W = rism_pkg::COUNT_W;
  localparam int NUM_KEYS = 1 << KEY_W;
  // No word is accepted and no result shows for this many cycles: give up.
  // The limit lies well above the slowest command plus the longest send gap.
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic                 found;
    logic [OUT_VAL_W-1:0] read_value;
    logic                 full_res;
    logic [COUNT_W-1:0]   count;
  } map_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_action = rism_pkg::ACT_GET;
  logic [KEY_W-1:0]     in_key = '0;
  logic [OUT_VAL_W-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_found;
  logic [OUT_VAL_W-1:0] out_read_value;
  logic                 out_full_res;
  logic [COUNT_W-1:0]   out_count;

  // Mirror of the map contents. The block keeps its values dense in key order,
  // but what it reports only depends on which keys hold which value, so track
  // them per key here and count the entries alongside.
  logic [NUM_KEYS-1:0]  key_present = '0;
  logic [OUT_VAL_W-1:0] stored_value [NUM_KEYS];
  int                   entry_count = 0;

  map_result_t pending_results[$];
  int          mismatch_cnt = 0;
  int          stall_cycles = 0;

  rank_indexed_sparse_map uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_full_res   (out_full_res),
    .out_count      (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the mirror and return the result word it must produce.
  function automatic map_result_t apply_command(rism_pkg::action_t act,
                                                logic [KEY_W-1:0] key,
                                                logic [OUT_VAL_W-1:0] val);
    map_result_t res;
    logic        in_space;
    res = '0;
    in_space = int'(key) < KEY_SPACE;
    res.found = in_space && key_present[key];
    case (act)
      rism_pkg::ACT_GET: begin
        if (res.found) res.read_value = stored_value[key];
      end
      rism_pkg::ACT_SET: begin
        if (!in_space) begin
          // key beyond the key space: ignore the set entirely
        end else if (key_present[key]) begin
          // overwrite in place, even when the store is full
          stored_value[key] = val;
        end else if (entry_count >= CAPACITY) begin
          res.full_res = 1'b1;
        end else begin
          key_present[key] = 1'b1;
          stored_value[key] = val;
          entry_count++;
        end
      end
      rism_pkg::ACT_REMOVE: begin
        // a remove of an absent key leaves everything alone
        if (res.found) begin
          key_present[key] = 1'b0;
          entry_count--;
        end
      end
      default: ; // unused action: report presence only, change nothing
    endcase
    res.count = COUNT_W'(entry_count);
    return res;
  endfunction

  // Return a key that is (or is not) present, starting the scan at a random
  // point; fall back to any key when none qualifies.
  function automatic logic [KEY_W-1:0] find_key(bit want_present);
    int base;
    int k;
    base = $urandom_range(NUM_KEYS - 1);
    for (int i = 0; i < NUM_KEYS; i++) begin
      k = (base + i) % NUM_KEYS;
      if (key_present[k] == want_present) return KEY_W'(k);
    end
    return KEY_W'(base);
  endfunction

  // Present one command word and hold it until the block takes it. start is
  // left high on return so that a following word can go out at once.
  task automatic send_word(rism_pkg::action_t act, logic [KEY_W-1:0] key,
                           logic [OUT_VAL_W-1:0] val);
    start <= 1'b1;
    in_action <= act;
    in_key <= key;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge: predict now, before any later word can change state
    pending_results.push_back(apply_command(act, key, val));
  endtask

  // Drop start for a burst of idle cycles.
  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle(bit allowed);
    if (allowed && $urandom_range(3) == 0) idle_cycles($urandom_range(1, 18));
  endtask

  task automatic note_mismatch(string field, logic [OUT_VAL_W-1:0] exp_v,
                               logic [OUT_VAL_W-1:0] got_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: MISMATCH %s: expected %0h, got %0h", $realtime, field, exp_v, got_v);
  endtask

  // Compare every result word with the oldest prediction, field by field.
  always @(posedge clk) begin
    map_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: MISMATCH result word with no command pending", $realtime);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_found !== exp_res.found) note_mismatch("found", exp_res.found, out_found);
        if (out_read_value !== exp_res.read_value)
          note_mismatch("read_value", exp_res.read_value, out_read_value);
        if (out_full_res !== exp_res.full_res)
          note_mismatch("full_res", exp_res.full_res, out_full_res);
        if (out_count !== exp_res.count) note_mismatch("count", exp_res.count, out_count);
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $realtime,
               pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Extremes of key and value, every word boundary of the bitmap, every action,
  // overwrite, removal of an absent key and the unused action.
  task automatic test_directed();
    send_word(rism_pkg::ACT_GET, 8'd0, 32'h0);              // empty map misses
    send_word(rism_pkg::ACT_SET, 8'd0, 32'h0);
    send_word(rism_pkg::ACT_SET, 8'd255, 32'hFFFF_FFFF);
    send_word(rism_pkg::ACT_SET, 8'd64, 32'hA5A5_5A5A);     // first key of second word
    send_word(rism_pkg::ACT_SET, 8'd63, 32'h5A5A_A5A5);     // last key of first word
    maybe_idle(1'b1);
    send_word(rism_pkg::ACT_SET, 8'd128, 32'h8000_0001);
    send_word(rism_pkg::ACT_SET, 8'd127, 32'h7FFF_FFFE);
    send_word(rism_pkg::ACT_SET, 8'd192, 32'h1234_5678);
    send_word(rism_pkg::ACT_SET, 8'd191, 32'h8765_4321);
    send_word(rism_pkg::ACT_GET, 8'd0, 32'hFFFF_FFFF);      // value ignored on get
    send_word(rism_pkg::ACT_GET, 8'd255, 32'h0);
    send_word(rism_pkg::ACT_GET, 8'd128, 32'h0);
    send_word(rism_pkg::ACT_SET, 8'd64, 32'hDEAD_BEEF);     // overwrite keeps the count
    send_word(rism_pkg::ACT_GET, 8'd64, 32'h0);
    maybe_idle(1'b1);
    send_word(rism_pkg::ACT_GET, 8'd100, 32'h0);
    send_word(rism_pkg::ACT_REMOVE, 8'd100, 32'h0);         // absent: nothing changes
    send_word(rism_pkg::ACT_REMOVE, 8'd64, 32'h0);
    send_word(rism_pkg::ACT_GET, 8'd64, 32'h0);
    send_word(rism_pkg::ACT_GET, 8'd127, 32'h0);            // slot moved down by the remove
    send_word(rism_pkg::ACT_NONE, 8'd0, 32'hFFFF_FFFF);     // present key, unused action
    send_word(rism_pkg::ACT_NONE, 8'd5, 32'h0);             // absent key, unused action
    send_word(rism_pkg::ACT_REMOVE, 8'd0, 32'h0);
    send_word(rism_pkg::ACT_GET, 8'd255, 32'h0);
    idle_cycles(1);
  endtask

  // Fill the store to capacity, then try new keys, overwrite and refill.
  task automatic test_store_full();
    logic [KEY_W-1:0] key;
    while (entry_count < CAPACITY) begin
      send_word(rism_pkg::ACT_SET, find_key(1'b0), $urandom);
      maybe_idle(1'b1);
    end
    send_word(rism_pkg::ACT_SET, find_key(1'b0), $urandom); // refused
    send_word(rism_pkg::ACT_SET, find_key(1'b0), $urandom); // refused again
    key = find_key(1'b1);
    send_word(rism_pkg::ACT_SET, key, $urandom);            // overwrite still allowed
    send_word(rism_pkg::ACT_GET, key, 32'h0);
    send_word(rism_pkg::ACT_NONE, key, 32'h0);
    send_word(rism_pkg::ACT_REMOVE, find_key(1'b1), 32'h0);
    send_word(rism_pkg::ACT_SET, find_key(1'b0), $urandom); // fits again
    send_word(rism_pkg::ACT_GET, find_key(1'b0), 32'h0);    // miss while full
    idle_cycles($urandom_range(1, 18));
  endtask

  // Random commands in segments whose set/remove balance differs, so the
  // population swings between empty and full. Late segments run without gaps.
  task automatic test_random_mix(int segments, int per_segment);
    int                set_weight;
    int                pick;
    bit                idle_on;
    bit                hit;
    rism_pkg::action_t act;
    for (int s = 0; s < segments; s++) begin
      case ($urandom_range(2))
        0: set_weight = 20;
        1: set_weight = 50;
        default: set_weight = 85;
      endcase
      idle_on = (s < segments - 2) && ($urandom_range(3) != 0);
      for (int i = 0; i < per_segment; i++) begin
        pick = $urandom_range(99);
        if (pick < 3) act = rism_pkg::ACT_NONE;
        else if (pick < 30) act = rism_pkg::ACT_GET;
        else if ($urandom_range(99) < set_weight) act = rism_pkg::ACT_SET;
        else act = rism_pkg::ACT_REMOVE;
        // mostly aim at stored keys so gets hit and removes do work
        hit = (act == rism_pkg::ACT_SET) ? ($urandom_range(3) == 0)
                                         : ($urandom_range(9) < 7);
        send_word(act, find_key(hit), $urandom);
        maybe_idle(idle_on);
      end
    end
  endtask

  initial begin
    // Hold reset, then release it before the first test.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_store_full();
    test_random_mix(14, 50);

    // Stop sending, wait out every outstanding result, then watch for strays.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: rank_indexed_sparse_map.f
hdl/rism_pkg.sv
hdl/rism_ram.sv
hdl/rism_word_mem.sv
hdl/rism_rank.sv
hdl/rank_indexed_sparse_map.sv
tb/tb_rank_indexed_sparse_map.sv
